### src/mqsb_pkg.sv
// Shared types, sizes and codes for the multi-queue shared buffer.
// Used by mqsb_store and multi_queue_shared_buffer; depends on nothing.
package mqsb_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned QUEUES = 4;

  // Pointer width holds every slot index plus the null pointer (value SLOTS).
  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DEQ
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [1:0]         queue_id;
    logic signed [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
  } out_item_t;

  // Read and write requests from the sequencer to the pointer and data stores.
  typedef struct packed {
    logic               ht_re;
    logic [QW-1:0]      ht_raddr;
    logic               link_re;
    logic [SW-1:0]      link_raddr;
    logic               data_re;
    logic [SW-1:0]      data_raddr;
    logic               head_we;
    logic               tail_we;
    logic [QW-1:0]      ht_waddr;
    logic [PW-1:0]      head_wdata;
    logic [PW-1:0]      tail_wdata;
    logic               link_we;
    logic [SW-1:0]      link_waddr;
    logic [PW-1:0]      link_wdata;
    logic               data_we;
    logic [SW-1:0]      data_waddr;
    logic signed [31:0] data_wdata;
  } store_req_t;

  typedef struct packed {
    logic [PW-1:0]      head_rd;
    logic [PW-1:0]      tail_rd;
    logic [PW-1:0]      link_rd;
    logic signed [31:0] data_rd;
  } store_rsp_t;

endpackage

### src/mqsb_store.sv
// Head, tail, link and data stores of the shared buffer, with registered reads.
// Depends on mqsb_pkg; head entries carry valid bits so unwritten heads read as null.
module mqsb_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mqsb_pkg::store_req_t req_i,
  output mqsb_pkg::store_rsp_t rsp_o
);
  import mqsb_pkg::*;

  logic [PW-1:0]      head_mem [QUEUES];
  logic [PW-1:0]      tail_mem [QUEUES];
  logic [PW-1:0]      link_mem [SLOTS];
  logic signed [31:0] data_mem [SLOTS];

  logic [QUEUES-1:0]  head_vld_q;
  store_rsp_t         rsp_q;

  // Valid bits: set on first head write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
    end else if (req_i.head_we) begin
      head_vld_q[req_i.ht_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.head_we) begin
      head_mem[req_i.ht_waddr] <= req_i.head_wdata;
    end
    if (req_i.tail_we) begin
      tail_mem[req_i.ht_waddr] <= req_i.tail_wdata;
    end
    if (req_i.link_we) begin
      link_mem[req_i.link_waddr] <= req_i.link_wdata;
    end
    if (req_i.data_we) begin
      data_mem[req_i.data_waddr] <= req_i.data_wdata;
    end
    if (req_i.ht_re) begin
      rsp_q.head_rd <= head_vld_q[req_i.ht_raddr] ? head_mem[req_i.ht_raddr] : NULL_PTR;
      rsp_q.tail_rd <= tail_mem[req_i.ht_raddr];
    end
    if (req_i.link_re) begin
      rsp_q.link_rd <= link_mem[req_i.link_raddr];
    end
    if (req_i.data_re) begin
      rsp_q.data_rd <= data_mem[req_i.data_raddr];
    end
  end

  assign rsp_o = rsp_q;

endmodule

### src/multi_queue_shared_buffer.sv
// Multi-queue shared buffer: QUEUES FIFO queues linked through one pool of SLOTS slots.
// Enqueue: taken in S_IDLE, result registered out of S_LOOK; no new request until then.
// Dequeue: taken in S_IDLE, S_LOOK fetches link and word, result registered out of S_DEQ.
// No new request is taken before the result is loaded; the steps follow from the registered store reads.
// Reset clears queue heads and the free list at once; a fill count stands in for the
// initial slot chain, so there is no clearing pass. A waiting result stalls the last step.
module multi_queue_shared_buffer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mqsb_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mqsb_pkg::out_item_t out_o
);
  import mqsb_pkg::*;

  state_e        state_q, state_d;
  in_item_t      req_q;
  logic          q_ok_q;
  logic [PW-1:0] free_head_q, free_head_d;
  // Slots at or above the fill count have never been handed out and still chain i -> i+1.
  logic [PW-1:0] fill_q, fill_d;

  out_item_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic          out_free;

  store_req_t    sreq;
  store_rsp_t    srsp;

  logic          accept;
  logic [QW-1:0] req_qidx;
  logic          enq_err;
  logic          deq_err;
  logic          fresh;
  logic [PW-1:0] next_free;

  mqsb_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sreq),
    .rsp_o  (srsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign req_qidx   = QW'(req_q.queue_id);

  assign enq_err = !q_ok_q || (free_head_q == NULL_PTR);
  assign deq_err = !q_ok_q || (srsp.head_rd == NULL_PTR);

  // An untouched slot links to its successor; the last one links to null (= SLOTS).
  assign fresh     = (free_head_q >= fill_q);
  assign next_free = fresh ? (free_head_q + PW'(1)) : srsp.link_rd;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (req_q.operation == OP_DEQ && !deq_err) begin
          state_d = S_DEQ;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DEQ: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Store requests, pointer updates and result.
  always_comb begin
    sreq        = '0;
    free_head_d = free_head_q;
    fill_d      = fill_q;
    out_load    = 1'b0;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        // Look up head and tail of the queue, and the successor of the free head.
        sreq.ht_re      = accept;
        sreq.ht_raddr   = QW'(in_i.queue_id);
        sreq.link_re    = accept;
        sreq.link_raddr = free_head_q[SW-1:0];
      end
      S_LOOK: begin
        if (req_q.operation == OP_ENQ) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_d.data_out = '0;
            if (enq_err) begin
              out_d.status = ST_FULL;
            end else begin
              out_d.status = ST_OK;
              // Take the free head, append it behind the tail.
              free_head_d = next_free;
              if (fresh) begin
                fill_d = fill_q + PW'(1);
              end
              sreq.ht_waddr   = req_qidx;
              sreq.tail_we    = 1'b1;
              sreq.tail_wdata = free_head_q;
              if (srsp.head_rd == NULL_PTR) begin
                sreq.head_we    = 1'b1;
                sreq.head_wdata = free_head_q;
              end else begin
                sreq.link_we    = 1'b1;
                sreq.link_waddr = srsp.tail_rd[SW-1:0];
                sreq.link_wdata = free_head_q;
              end
              sreq.data_we    = 1'b1;
              sreq.data_waddr = free_head_q[SW-1:0];
              sreq.data_wdata = req_q.data_in;
            end
          end
        end else if (deq_err) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_d.data_out = '0;
            out_d.status   = ST_EMPTY;
          end
        end else begin
          // Fetch the head slot's link and word.
          sreq.link_re    = 1'b1;
          sreq.link_raddr = srsp.head_rd[SW-1:0];
          sreq.data_re    = 1'b1;
          sreq.data_raddr = srsp.head_rd[SW-1:0];
        end
      end
      S_DEQ: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_d.data_out = srsp.data_rd;
          out_d.status   = ST_OK;
          // Unlink the head; the tail slot's link is never written, so drop to null there.
          sreq.ht_waddr   = req_qidx;
          sreq.head_we    = 1'b1;
          sreq.head_wdata = (srsp.head_rd == srsp.tail_rd) ? NULL_PTR : srsp.link_rd;
          // Push the slot back onto the free list.
          sreq.link_we    = 1'b1;
          sreq.link_waddr = srsp.head_rd[SW-1:0];
          sreq.link_wdata = free_head_q;
          free_head_d     = srsp.head_rd;
        end
      end
      default: begin
        sreq = '0;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the request and the result word; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_i;
      q_ok_q <= (32'(in_i.queue_id) < 32'(QUEUES));
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### bench/multi_queue_shared_buffer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for multi_queue_shared_buffer: directed, fill, stall and random requests.
// Depends on mqsb_pkg for the request and result structs and codes; needs nothing else.
module multi_queue_shared_buffer_tb;
  import mqsb_pkg::*;

  // Quiet cycles tolerated before the run is declared hung; the longest correct quiet
  // stretch is the receiver hold-off below plus a short sender gap.
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 160;
  localparam int unsigned MAX_REPORTS = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  multi_queue_shared_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  // Shadow copy of the linked lists: per-queue head and tail, slot links, slot words
  // and the top of the free list. NULL_PTR marks an empty list.
  logic [PW-1:0]      q_head    [QUEUES];
  logic [PW-1:0]      q_tail    [QUEUES];
  logic [PW-1:0]      slot_link [SLOTS];
  logic signed [31:0] slot_word [SLOTS];
  logic [PW-1:0]      free_top;

  out_item_t   expected_results[$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_ok;
  int unsigned results_full;
  int unsigned results_empty;

  // Shared controls: calm switches off idling on both sides; a non-zero sink_hold asks
  // the receiver to hold off for that many cycles.
  bit          calm;
  int unsigned sink_hold;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_slot(input logic [PW-1:0] p);
    return p < PW'(SLOTS);
  endfunction

  // Apply one request to the shadow lists and return the result it must produce.
  function automatic out_item_t predict_queue_op(input in_item_t req);
    out_item_t     res;
    logic [PW-1:0] s;
    int unsigned   q;
    res.data_out = '0;
    res.status   = ST_OK;
    q = req.queue_id;
    if (req.operation == OP_ENQ) begin
      if (q >= QUEUES || !is_slot(free_top)) begin
        res.status = ST_FULL;
      end else begin
        s = free_top;
        free_top = slot_link[s[SW-1:0]];
        // A null head means the queue is empty; ignore a stale tail in that case.
        if (!is_slot(q_head[q])) begin
          q_head[q] = s;
        end else if (is_slot(q_tail[q])) begin
          slot_link[q_tail[q][SW-1:0]] = s;
        end
        slot_link[s[SW-1:0]] = NULL_PTR;
        q_tail[q]            = s;
        slot_word[s[SW-1:0]] = req.data_in;
      end
    end else begin
      if (q >= QUEUES || !is_slot(q_head[q])) begin
        res.status = ST_EMPTY;
      end else begin
        s = q_head[q];
        q_head[q]            = slot_link[s[SW-1:0]];
        slot_link[s[SW-1:0]] = free_top;
        free_top             = s;
        res.data_out         = slot_word[s[SW-1:0]];
      end
    end
    return res;
  endfunction

  function automatic in_item_t make_req(input op_e op, input logic [1:0] q,
                                        input logic signed [31:0] d);
    in_item_t req;
    req.operation = op;
    req.queue_id  = q;
    req.data_in   = d;
    return req;
  endfunction

  // Mostly full-range words, now and then one of the extremes, zero or minus one.
  function automatic logic signed [31:0] rand_word();
    logic signed [31:0] w;
    case ($urandom_range(0, 15))
      0:       w = 32'sh8000_0000;
      1:       w = 32'sh7FFF_FFFF;
      2:       w = '0;
      3:       w = -32'sd1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Offer one request, hold it until taken, record its expected result, then maybe idle.
  // Valid stays high into the next request when no gap is drawn.
  task automatic send_request(input in_item_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    expected_results.push_back(predict_queue_op(req));
    requests_sent++;
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold off until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Extremes of the data word, every queue empty and filled, and the stale tail left
  // behind when a queue runs dry.
  task automatic test_directed();
    for (int q = 0; q < QUEUES; q++) begin
      send_request(make_req(OP_DEQ, 2'(q), (q % 2) ? 32'sh7FFF_FFFF : -32'sd1));
    end
    send_request(make_req(OP_ENQ, 2'd0, 32'sh8000_0000));
    send_request(make_req(OP_ENQ, 2'd1, 32'sh7FFF_FFFF));
    send_request(make_req(OP_ENQ, 2'd2, 32'sd0));
    send_request(make_req(OP_ENQ, 2'd3, -32'sd1));
    send_request(make_req(OP_DEQ, 2'd3, '0));
    send_request(make_req(OP_DEQ, 2'd2, '0));
    send_request(make_req(OP_DEQ, 2'd1, '0));
    send_request(make_req(OP_DEQ, 2'd0, '0));
    // Empty queue 2, refuse once more, then refill it over the stale tail.
    send_request(make_req(OP_ENQ, 2'd2, 32'sh5A5A_5A5A));
    send_request(make_req(OP_DEQ, 2'd2, '0));
    send_request(make_req(OP_DEQ, 2'd2, 32'shFFFF_0000));
    send_request(make_req(OP_ENQ, 2'd2, 32'shA5A5_A5A5));
    send_request(make_req(OP_ENQ, 2'd2, 32'sh1234_5678));
    send_request(make_req(OP_DEQ, 2'd2, '0));
    send_request(make_req(OP_DEQ, 2'd2, '0));
    // Interleave two queues so their slots alternate in the pool.
    send_request(make_req(OP_ENQ, 2'd1, 32'sh0F0F_0F0F));
    send_request(make_req(OP_ENQ, 2'd0, 32'shF0F0_F0F0));
    send_request(make_req(OP_ENQ, 2'd1, 32'sh0000_0001));
    send_request(make_req(OP_DEQ, 2'd1, '0));
    send_request(make_req(OP_DEQ, 2'd0, '0));
    send_request(make_req(OP_DEQ, 2'd1, '0));
    wait_drained();
  endtask

  // Use up every slot, have enqueues refused, reuse one freed slot, then drain.
  task automatic test_buffer_full();
    for (int i = 0; i < SLOTS; i++) begin
      send_request(make_req(OP_ENQ, 2'(i % QUEUES), rand_word()));
    end
    send_request(make_req(OP_ENQ, 2'd1, rand_word()));
    send_request(make_req(OP_ENQ, 2'd3, rand_word()));
    send_request(make_req(OP_DEQ, 2'd2, rand_word()));
    send_request(make_req(OP_ENQ, 2'd0, rand_word()));
    send_request(make_req(OP_ENQ, 2'd2, rand_word()));
    for (int q = 0; q < QUEUES; q++) begin
      repeat (SLOTS / QUEUES + 2) send_request(make_req(OP_DEQ, 2'(q), rand_word()));
    end
    wait_drained();
  endtask

  // Hold the receiver off while requests keep coming, so the block backs up onto its input.
  task automatic test_receiver_hold();
    sink_hold = HOLD_CYCLES;
    repeat (40) begin
      send_request(make_req(($urandom_range(0, 99) < 60) ? OP_ENQ : OP_DEQ,
                            2'($urandom_range(0, QUEUES - 1)), rand_word()));
    end
    wait_drained();
  endtask

  // Random requests in blocks; each block leans towards enqueue or dequeue or is even, so the pool
  // swings between full and empty, and some blocks stay on one queue.
  task automatic test_random(input int unsigned count, input bit no_idle);
    int unsigned bias;
    int unsigned sent;
    int          one_queue;
    calm = no_idle;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 3))
        0:       bias = 20;
        1:       bias = 50;
        2:       bias = 75;
        default: bias = 90;
      endcase
      one_queue = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, QUEUES - 1)) : -1;
      repeat ($urandom_range(20, 60)) begin
        send_request(make_req(($urandom_range(0, 99) < bias) ? OP_ENQ : OP_DEQ,
                              (one_queue < 0) ? 2'($urandom_range(0, 3)) : 2'(one_queue),
                              rand_word()));
        sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
    wait_drained();
    calm = 1'b0;
  endtask

  // Receiver: drop ready at random, or for a whole hold-off when asked.
  initial begin : result_sink
    int unsigned hold;
    out_ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold != 0) begin
        hold = sink_hold;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
        sink_hold = 0;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // Compare every taken result with the oldest expectation, field by field.
  initial begin : result_check
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
        case (out_data.status)
          ST_OK:    results_ok++;
          ST_FULL:  results_full++;
          ST_EMPTY: results_empty++;
          default:  ;
        endcase
        if (expected_results.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("unexpected result: data %0d status %0d", out_data.data_out,
                     out_data.status);
          end
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.data_out !== want.data_out || out_data.status !== want.status) begin
            if (mismatches < MAX_REPORTS) begin
              $display("mismatch at %0t: expected data %0d status %0d, got data %0d status %0d",
                       $realtime, want.data_out, want.status, out_data.data_out,
                       out_data.status);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: end the run once too many cycles pass with neither channel moving.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: %0d quiet cycles, %0d results outstanding", quiet,
             expected_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : run
    in_valid  <= 1'b0;
    in_data   <= '0;
    rst_ni    <= 1'b0;
    calm      = 1'b0;
    sink_hold = 0;
    mismatches    = 0;
    requests_sent = 0;
    results_ok    = 0;
    results_full  = 0;
    results_empty = 0;
    // Initialise the shadow lists to the reset picture: all queues empty, slots chained.
    for (int q = 0; q < QUEUES; q++) begin
      q_head[q] = NULL_PTR;
      q_tail[q] = NULL_PTR;
    end
    for (int i = 0; i < SLOTS; i++) begin
      slot_link[i] = PW'(i + 1);
      slot_word[i] = '0;
    end
    slot_link[SLOTS - 1] = NULL_PTR;
    free_top = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_buffer_full();
    test_receiver_hold();
    test_random(80, 1'b1);
    test_random(470, 1'b0);

    // Let the pipeline settle past its longest latency before judging.
    repeat (10) @(posedge clk_i);
    $display("covered %0d requests: %0d ok, %0d refused full, %0d refused empty",
             requests_sent, results_ok, results_full, results_empty);
    $display("%0d mismatches, %0d results never arrived", mismatches,
             expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
